/* rtl/wpp_pkg.sv */
// Shared constants and register index codes for the world point projection core.
`default_nettype none
package wpp_pkg;

  localparam int POINT_WIDTH = 32;
  localparam int DATA_WIDTH  = 64;
  localparam int SIZE_WIDTH  = 14;
  localparam int ADDR_WIDTH  = 3;
  localparam int QUOT_BITS   = 33;
  localparam int NUM_ROWS    = 3;
  localparam int NUM_TERMS   = 4;

  typedef enum logic [ADDR_WIDTH-1:0] {
    REG_X_ROW_LOW  = 3'd0,
    REG_X_ROW_HIGH = 3'd1,
    REG_Y_ROW_LOW  = 3'd2,
    REG_Y_ROW_HIGH = 3'd3,
    REG_W_ROW_LOW  = 3'd4,
    REG_W_ROW_HIGH = 3'd5,
    REG_VP_WIDTH   = 3'd6,
    REG_VP_HEIGHT  = 3'd7
  } cfg_reg_t;

  localparam logic [DATA_WIDTH-1:0] RST_X_ROW_LOW  = 64'd65536;
  localparam logic [DATA_WIDTH-1:0] RST_X_ROW_HIGH = 64'd0;
  localparam logic [DATA_WIDTH-1:0] RST_Y_ROW_LOW  = 64'd281474976710656;
  localparam logic [DATA_WIDTH-1:0] RST_Y_ROW_HIGH = 64'd0;
  localparam logic [DATA_WIDTH-1:0] RST_W_ROW_LOW  = 64'd0;
  localparam logic [DATA_WIDTH-1:0] RST_W_ROW_HIGH = 64'd281474976710656;
  localparam logic [SIZE_WIDTH-1:0] RST_VP_WIDTH   = 14'd640;
  localparam logic [SIZE_WIDTH-1:0] RST_VP_HEIGHT  = 14'd480;

  localparam logic [QUOT_BITS-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
  localparam logic [QUOT_BITS-1:0] LIMIT_NEG = 33'h0_8000_0000;

endpackage
`default_nettype wire

/* rtl/world_point_to_pixel_projection_core.sv */
// Pipelined world point to pixel projection with per-bit restoring dividers.
//
//   Channel   Signals                                      Direction
//   command   start, busy, point_x, point_y, point_z       in (busy out)
//   result    done, visible, pixel_x, pixel_y              out
//   config    cfg_we, cfg_addr, cfg_data                   in
//
// One point enters every cycle outside reset; results leave in the order the points entered.
// Two dividers resolve one quotient bit per stage
// for 33 stages, after five stages of multiply, row sum, offset, scale and range check.
// Busy is high only during reset; the pipeline never stalls.
// Synchronous reset clears the valid bits and loads the register reset values.
`default_nettype none
module world_point_to_pixel_projection_core #(
  parameter int COEFF_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  wire signed [wpp_pkg::POINT_WIDTH-1:0] point_x,
  input  wire signed [wpp_pkg::POINT_WIDTH-1:0] point_y,
  input  wire signed [wpp_pkg::POINT_WIDTH-1:0] point_z,
  output logic                                  done,
  output logic                                  visible,
  output logic signed [wpp_pkg::POINT_WIDTH-1:0] pixel_x,
  output logic signed [wpp_pkg::POINT_WIDTH-1:0] pixel_y,
  input  wire                                   cfg_we,
  input  wire [wpp_pkg::ADDR_WIDTH-1:0]         cfg_addr,
  input  wire [wpp_pkg::DATA_WIDTH-1:0]         cfg_data
);

  localparam int PW  = COEFF_WIDTH + wpp_pkg::POINT_WIDTH;
  localparam int SW  = PW + 2;
  localparam int CW  = SW - FRAC_BITS + 1;
  localparam int DW  = CW + 1;
  localparam int MPW = DW + wpp_pkg::SIZE_WIDTH;
  localparam int NW  = MPW + FRAC_BITS;
  localparam int QB  = wpp_pkg::QUOT_BITS;
  localparam int LAT = QB + 6;

  logic [wpp_pkg::DATA_WIDTH-1:0] row_reg [0:5];
  logic [wpp_pkg::SIZE_WIDTH-1:0] vp_width;
  logic [wpp_pkg::SIZE_WIDTH-1:0] vp_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_reg[0] <= wpp_pkg::RST_X_ROW_LOW;
      row_reg[1] <= wpp_pkg::RST_X_ROW_HIGH;
      row_reg[2] <= wpp_pkg::RST_Y_ROW_LOW;
      row_reg[3] <= wpp_pkg::RST_Y_ROW_HIGH;
      row_reg[4] <= wpp_pkg::RST_W_ROW_LOW;
      row_reg[5] <= wpp_pkg::RST_W_ROW_HIGH;
      vp_width   <= wpp_pkg::RST_VP_WIDTH;
      vp_height  <= wpp_pkg::RST_VP_HEIGHT;
    end else if (cfg_we) begin
      case (wpp_pkg::cfg_reg_t'(cfg_addr))
        wpp_pkg::REG_X_ROW_LOW:  row_reg[0] <= cfg_data;
        wpp_pkg::REG_X_ROW_HIGH: row_reg[1] <= cfg_data;
        wpp_pkg::REG_Y_ROW_LOW:  row_reg[2] <= cfg_data;
        wpp_pkg::REG_Y_ROW_HIGH: row_reg[3] <= cfg_data;
        wpp_pkg::REG_W_ROW_LOW:  row_reg[4] <= cfg_data;
        wpp_pkg::REG_W_ROW_HIGH: row_reg[5] <= cfg_data;
        wpp_pkg::REG_VP_WIDTH:   vp_width   <= cfg_data[wpp_pkg::SIZE_WIDTH-1:0];
        wpp_pkg::REG_VP_HEIGHT:  vp_height  <= cfg_data[wpp_pkg::SIZE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COEFF_WIDTH-1:0] coef [0:wpp_pkg::NUM_ROWS-1][0:wpp_pkg::NUM_TERMS-1];

  for (genvar r = 0; r < wpp_pkg::NUM_ROWS; r++) begin : g_row
    for (genvar k = 0; k < wpp_pkg::NUM_TERMS; k++) begin : g_term
      assign coef[r][k] = row_reg[2*r + k/2][32*(k%2) +: COEFF_WIDTH];
    end
  end

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // Stage A: nine products.
  logic                 a_valid;
  logic signed [PW-1:0] a_prod [0:wpp_pkg::NUM_ROWS-1][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  for (genvar r = 0; r < wpp_pkg::NUM_ROWS; r++) begin : g_mul
    always_ff @(posedge clk) begin
      a_prod[r][0] <= PW'(coef[r][0] * point_x);
      a_prod[r][1] <= PW'(coef[r][1] * point_y);
      a_prod[r][2] <= PW'(coef[r][2] * point_z);
    end
  end

  // Stage B: row sums floored to the fixed-point grid, plus the constant term.
  logic                 b_valid;
  logic signed [CW-1:0] b_clip [0:wpp_pkg::NUM_ROWS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  for (genvar r = 0; r < wpp_pkg::NUM_ROWS; r++) begin : g_sum
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;
    assign sum     = SW'(a_prod[r][0]) + SW'(a_prod[r][1]) + SW'(a_prod[r][2]);
    assign shifted = sum >>> FRAC_BITS;
    always_ff @(posedge clk) begin
      b_clip[r] <= shifted[CW-1:0] + CW'(coef[r][3]);
    end
  end

  // Stage C: visibility, signed numerators and divisor.
  logic                 c_valid;
  logic                 c_vis;
  logic                 c_neg_x;
  logic                 c_neg_y;
  logic [DW-1:0]        c_mag_x;
  logic [DW-1:0]        c_mag_y;
  logic [DW-1:0]        c_div;
  logic signed [DW-1:0] num_x;
  logic signed [DW-1:0] num_y;

  assign num_x = DW'(b_clip[0]) + DW'(b_clip[2]);
  assign num_y = DW'(b_clip[2]) - DW'(b_clip[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_vis   <= (b_clip[2] > 0) && (vp_width != '0) && (vp_height != '0);
    c_neg_x <= num_x[DW-1];
    c_neg_y <= num_y[DW-1];
    c_mag_x <= num_x[DW-1] ? DW'(-num_x) : DW'(num_x);
    c_mag_y <= num_y[DW-1] ? DW'(-num_y) : DW'(num_y);
    c_div   <= {b_clip[2][CW-1:0], 1'b0};
  end

  // Stage D: scale by viewport size.
  logic           d_valid;
  logic           d_vis;
  logic           d_neg_x;
  logic           d_neg_y;
  logic [MPW-1:0] d_prod_x;
  logic [MPW-1:0] d_prod_y;
  logic [DW-1:0]  d_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_vis    <= c_vis;
    d_neg_x  <= c_neg_x;
    d_neg_y  <= c_neg_y;
    d_prod_x <= MPW'(c_mag_x) * MPW'(vp_width);
    d_prod_y <= MPW'(c_mag_y) * MPW'(vp_height);
    d_div    <= c_div;
  end

  // Stage E: overflow check on the quotient range and remainder seed.
  logic [NW-1:0] numer_x;
  logic [NW-1:0] numer_y;
  logic [NW-1:0] high_x;
  logic [NW-1:0] high_y;

  assign numer_x = {d_prod_x, {FRAC_BITS{1'b0}}};
  assign numer_y = {d_prod_y, {FRAC_BITS{1'b0}}};
  assign high_x  = numer_x >> QB;
  assign high_y  = numer_y >> QB;

  logic          s_valid [0:QB];
  logic          s_vis   [0:QB];
  logic          s_neg_x [0:QB];
  logic          s_neg_y [0:QB];
  logic          s_ovf_x [0:QB];
  logic          s_ovf_y [0:QB];
  logic [DW-1:0] s_div   [0:QB];
  logic [DW-1:0] s_rem_x [0:QB];
  logic [DW-1:0] s_rem_y [0:QB];
  logic [QB-1:0] s_low_x [0:QB];
  logic [QB-1:0] s_low_y [0:QB];
  logic [QB-1:0] s_quo_x [0:QB];
  logic [QB-1:0] s_quo_y [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else begin
      s_valid[0] <= d_valid;
    end
    s_vis[0]   <= d_vis;
    s_neg_x[0] <= d_neg_x;
    s_neg_y[0] <= d_neg_y;
    s_ovf_x[0] <= high_x >= NW'(d_div);
    s_ovf_y[0] <= high_y >= NW'(d_div);
    s_div[0]   <= d_div;
    s_rem_x[0] <= high_x[DW-1:0];
    s_rem_y[0] <= high_y[DW-1:0];
    s_low_x[0] <= numer_x[QB-1:0];
    s_low_y[0] <= numer_y[QB-1:0];
    s_quo_x[0] <= '0;
    s_quo_y[0] <= '0;
  end

  // Division stages: one quotient bit each, most significant first.
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [DW:0] trial_x;
    logic [DW:0] trial_y;
    logic        take_x;
    logic        take_y;
    assign trial_x = {s_rem_x[i], s_low_x[i][QB-1]};
    assign trial_y = {s_rem_y[i], s_low_y[i][QB-1]};
    assign take_x  = trial_x >= (DW+1)'(s_div[i]);
    assign take_y  = trial_y >= (DW+1)'(s_div[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[i+1] <= 1'b0;
      end else begin
        s_valid[i+1] <= s_valid[i];
      end
      s_vis[i+1]   <= s_vis[i];
      s_neg_x[i+1] <= s_neg_x[i];
      s_neg_y[i+1] <= s_neg_y[i];
      s_ovf_x[i+1] <= s_ovf_x[i];
      s_ovf_y[i+1] <= s_ovf_y[i];
      s_div[i+1]   <= s_div[i];
      s_rem_x[i+1] <= take_x ? DW'(trial_x - (DW+1)'(s_div[i])) : trial_x[DW-1:0];
      s_rem_y[i+1] <= take_y ? DW'(trial_y - (DW+1)'(s_div[i])) : trial_y[DW-1:0];
      s_low_x[i+1] <= {s_low_x[i][QB-2:0], 1'b0};
      s_low_y[i+1] <= {s_low_y[i][QB-2:0], 1'b0};
      s_quo_x[i+1] <= {s_quo_x[i][QB-2:0], take_x};
      s_quo_y[i+1] <= {s_quo_y[i][QB-2:0], take_y};
    end
  end

  // Output stage: saturation, sign and visibility.
  logic [QB-1:0] lim_x;
  logic [QB-1:0] lim_y;
  logic [QB-1:0] sat_x;
  logic [QB-1:0] sat_y;

  assign lim_x = s_neg_x[QB] ? wpp_pkg::LIMIT_NEG : wpp_pkg::LIMIT_POS;
  assign lim_y = s_neg_y[QB] ? wpp_pkg::LIMIT_NEG : wpp_pkg::LIMIT_POS;
  assign sat_x = (s_ovf_x[QB] || s_quo_x[QB] > lim_x) ? lim_x : s_quo_x[QB];
  assign sat_y = (s_ovf_y[QB] || s_quo_y[QB] > lim_y) ? lim_y : s_quo_y[QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_valid[QB];
    end
    visible <= s_vis[QB];
    if (!s_vis[QB]) begin
      pixel_x <= '0;
      pixel_y <= '0;
    end else begin
      pixel_x <= s_neg_x[QB] ? -sat_x[wpp_pkg::POINT_WIDTH-1:0]
                             : sat_x[wpp_pkg::POINT_WIDTH-1:0];
      pixel_y <= s_neg_y[QB] ? -sat_y[wpp_pkg::POINT_WIDTH-1:0]
                             : sat_y[wpp_pkg::POINT_WIDTH-1:0];
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (done || $past(accept, LAT)) |-> (done && $past(accept, LAT)))
    else $error("result strobe does not match the pipeline latency");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !visible) |-> (pixel_x == '0 && pixel_y == '0))
    else $error("hidden result carries nonzero pixels");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

  a_empty_vp: assert property (@(posedge clk) disable iff (rst)
    (c_valid && c_vis) |-> ($past(vp_width) != '0 && $past(vp_height) != '0))
    else $error("visible point with an empty viewport");

endmodule
`default_nettype wire

/* tb/world_point_to_pixel_projection_core_tb.sv */
// Self-checking testbench for the world point to pixel projection core.
`timescale 1ns / 1ps
module world_point_to_pixel_projection_core_tb;

  typedef struct {
    logic        vis;
    logic [31:0] px;
    logic [31:0] py;
  } pixel_t;

  typedef struct {
    bit                wr;
    wpp_pkg::cfg_reg_t idx;
    logic [63:0]       val;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
    bit                typed;
    pixel_t            res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic [31:0] point_z = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [63:0] cfg_data = '0;
  wire         busy;
  wire         done;
  wire         visible;
  wire  [31:0] pixel_x;
  wire  [31:0] pixel_y;

  logic [63:0] row_mirror [6];
  logic [13:0] vp_w;
  logic [13:0] vp_h;
  pixel_t      pixel_q [$];
  int          errors = 0;
  int          idle_pct = 0;

  always #4 clk = ~clk;

  world_point_to_pixel_projection_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .done(done), .visible(visible), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  function automatic logic signed [127:0] coeff_of(int r, int k);
    logic [63:0]        reg_val;
    logic signed [31:0] half;
    reg_val = row_mirror[r * 2 + k / 2];
    half = (k % 2) ? reg_val[63:32] : reg_val[31:0];
    return 128'(half);
  endfunction

  function automatic logic [31:0] scale_to_pixels(logic signed [127:0] num, logic [13:0] dim,
                                                   logic signed [127:0] w);
    logic [127:0] mag;
    logic [127:0] q;
    bit           neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag * dim) << 16) / (w * 2);
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic pixel_t project(logic signed [31:0] x, logic signed [31:0] y,
                                     logic signed [31:0] z);
    logic signed [127:0] clip [3];
    logic signed [127:0] px;
    logic signed [127:0] py;
    logic signed [127:0] pz;
    logic signed [127:0] sum;
    pixel_t              res;
    px = x;
    py = y;
    pz = z;
    for (int r = 0; r < 3; r++) begin
      sum = coeff_of(r, 0) * px + coeff_of(r, 1) * py + coeff_of(r, 2) * pz;
      clip[r] = (sum >>> 16) + coeff_of(r, 3);
    end
    res = '{1'b0, 32'd0, 32'd0};
    if (clip[2] > 0 && vp_w != 0 && vp_h != 0) begin
      res.vis = 1'b1;
      res.px = scale_to_pixels(clip[0] + clip[2], vp_w, clip[2]);
      res.py = scale_to_pixels(clip[2] - clip[1], vp_h, clip[2]);
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (pixel_q.size() == 0) begin
        report("unexpected result", pixel_x, 32'd0);
      end else begin
        want = pixel_q.pop_front();
        if (visible !== want.vis) report("visible", 32'(visible), 32'(want.vis));
        if (pixel_x !== want.px) report("pixel_x", pixel_x, want.px);
        if (pixel_y !== want.py) report("pixel_y", pixel_y, want.py);
      end
    end
  end

  task automatic drain();
    start = 1'b0;
    wait (pixel_q.size() == 0);
    repeat (45) @(negedge clk);
  endtask

  task automatic cfg_write(wpp_pkg::cfg_reg_t idx, logic [63:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    if (idx < wpp_pkg::REG_VP_WIDTH) row_mirror[idx] = val;
    else if (idx == wpp_pkg::REG_VP_WIDTH) vp_w = val[13:0];
    else vp_h = val[13:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit typed, pixel_t res);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    point_x = x;
    point_y = y;
    point_z = z;
    do @(posedge clk); while (busy);
    pixel_q.push_back(typed ? res : project(x, y, z));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coeff(int mode);
    case (mode)
      0: return $urandom;
      1: return {{15{1'($urandom_range(1))}}, 17'($urandom)};
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_point();
    if ($urandom_range(2) == 0) return $urandom;
    return {{12{1'($urandom_range(1))}}, 20'($urandom)};
  endfunction

  task automatic rand_config(int mode);
    logic [31:0] c3;
    logic [13:0] sizes [4];
    sizes = '{14'd8192, 14'd16383, 14'd1, 14'd0};
    for (int r = 0; r < 6; r++) begin
      c3 = rand_coeff(mode);
      if (mode == 1 && r == 5) c3 = $urandom_range(32'h0004_0000, 32'h0000_1000);
      cfg_write(wpp_pkg::cfg_reg_t'(r), {rand_coeff(mode), (r % 2) ? rand_coeff(mode) : c3});
    end
    if (mode == 2) begin
      cfg_write(wpp_pkg::REG_VP_WIDTH, {50'($urandom), sizes[$urandom_range(3)]});
      cfg_write(wpp_pkg::REG_VP_HEIGHT, {50'($urandom), sizes[$urandom_range(3)]});
    end else begin
      cfg_write(wpp_pkg::REG_VP_WIDTH,
                {$urandom, 18'($urandom), 14'($urandom_range(8192, 1))});
      cfg_write(wpp_pkg::REG_VP_HEIGHT, {$urandom, $urandom});
    end
  endtask

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    row_t plan [];
    pixel_t off;
    off = '{1'b0, 32'd0, 32'd0};
    plan = '{
      '{0, wpp_pkg::REG_X_ROW_LOW, 64'd0, 32'd0, 32'd0, 32'd0, 1,
        '{1'b1, 32'd20971520, 32'd15728640}},
      '{0, wpp_pkg::REG_X_ROW_LOW, 64'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1,
        '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
      '{0, wpp_pkg::REG_X_ROW_LOW, 64'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1,
        '{1'b1, 32'h8000_0000, 32'h8000_0000}},
      '{0, wpp_pkg::REG_X_ROW_LOW, 64'd0,
        32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 0, off},
      '{0, wpp_pkg::REG_X_ROW_LOW, 64'd0,
        32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000, 0, off},
      '{1, wpp_pkg::REG_W_ROW_HIGH, 64'd0, 32'd0, 32'd0, 32'd0, 1, off},
      '{1, wpp_pkg::REG_W_ROW_HIGH, 64'hFFFF_0000_0000_0000, 32'd1, 32'd2, 32'd3, 1, off},
      '{1, wpp_pkg::REG_W_ROW_HIGH, wpp_pkg::RST_W_ROW_HIGH,
        32'h0000_8000, 32'd5, 32'd0, 0, off},
      '{1, wpp_pkg::REG_VP_WIDTH, 64'd0, 32'd7, 32'd9, 32'd0, 1, off},
      '{1, wpp_pkg::REG_VP_WIDTH, 64'd640, 32'h0000_4000, 32'hFFFF_C000, 32'd0, 0, off},
      '{1, wpp_pkg::REG_VP_HEIGHT, 64'd0, 32'd3, 32'd4, 32'd0, 1, off},
      '{1, wpp_pkg::REG_VP_HEIGHT, 64'd16383, 32'h0000_2000, 32'h0000_9000, 32'd0, 0, off},
      '{1, wpp_pkg::REG_VP_WIDTH, 64'hFFFF_FFFF_FFFF_E000,
        32'h7FFF_FFFF, 32'd0, 32'd0, 0, off},
      '{1, wpp_pkg::REG_X_ROW_LOW, 64'h8000_0000_7FFF_FFFF,
        32'h0003_0000, 32'h0002_0000, 32'd0, 0, off},
      '{1, wpp_pkg::REG_X_ROW_HIGH, 64'h0001_0000_0000_8000,
        32'd1, 32'd1, 32'h0001_0000, 0, off},
      '{1, wpp_pkg::REG_Y_ROW_LOW, 64'hFFFF_0000_0000_8000,
        32'h0001_0000, 32'h0001_0000, 32'd0, 0, off},
      '{1, wpp_pkg::REG_Y_ROW_HIGH, 64'h7FFF_FFFF_8000_0000,
        32'd0, 32'd0, 32'h0000_0100, 0, off},
      '{1, wpp_pkg::REG_W_ROW_LOW, 64'h0000_0100_0000_0100,
        32'h0100_0000, 32'h0200_0000, 32'd0, 0, off}
    };
    for (int r = 0; r < 6; r++) row_mirror[r] = 64'd0;
    row_mirror[wpp_pkg::REG_X_ROW_LOW] = wpp_pkg::RST_X_ROW_LOW;
    row_mirror[wpp_pkg::REG_Y_ROW_LOW] = wpp_pkg::RST_Y_ROW_LOW;
    row_mirror[wpp_pkg::REG_W_ROW_HIGH] = wpp_pkg::RST_W_ROW_HIGH;
    vp_w = wpp_pkg::RST_VP_WIDTH;
    vp_h = wpp_pkg::RST_VP_HEIGHT;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    while (busy) @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        drain();
        cfg_write(plan[i].idx, plan[i].val);
      end
      send(plan[i].x, plan[i].y, plan[i].z, plan[i].typed, plan[i].res);
    end

    for (int phase = 0; phase < 12; phase++) begin
      idle_pct = (phase < 4) ? 31 : (phase < 8) ? 49 : 0;
      drain();
      rand_config((phase % 4 == 3) ? 2 : (phase % 4 == 0) ? 0 : 1);
      for (int n = 0; n < 160; n++) begin
        if (n == 80) begin
          start = 1'b0;
          wait (pixel_q.size() == 0);
          @(negedge clk);
        end
        send(rand_point(), rand_point(), rand_point(), 0, off);
      end
    end
    start = 1'b0;
    wait (pixel_q.size() == 0);
    repeat (60) @(negedge clk);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
